// ===== design/base64_stream_encoder_core_macros.svh =====
// Assertion macros shared by the base64 encoder checkers.
// Each macro expects signals named clock and reset in the enclosing scope.
`ifndef BASE64_STREAM_ENCODER_CORE_MACROS_SVH
`define BASE64_STREAM_ENCODER_CORE_MACROS_SVH

// Implication into the next cycle, ignored while reset is high.
`define B64SE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication into the next cycle, checked during reset as well.
`define B64SE_ASSERT_RESET(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/b64se_pkg.sv =====
// Shared types, constants and the symbol lookup for the base64 encoder.
// No dependencies.
package b64se_pkg;

   localparam logic [7:0] PAD_CHAR    = 8'h3D;
   localparam logic [5:0] SIX_MASK    = 6'h3F;
   localparam int         QUEUE_DEPTH = 2;
   localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int         QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One completed (possibly padded) group waiting for the back end.
   typedef struct packed {
      logic [23:0] group;
      logic [1:0]  pad_count;   // number of trailing '=' characters
      logic        last;        // group ends the message
   } group_entry_type;

   // Queue status seen by the front and back ends.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
   function automatic logic [7:0] symbol_char(input logic [5:0] idx);
      logic [7:0] code;
      code = 8'h2F;
      if (idx < 6'd26) begin
         code = 8'h41 + {2'b00, idx};
      end else if (idx < 6'd52) begin
         code = 8'h61 + {2'b00, idx - 6'd26};
      end else if (idx < 6'd62) begin
         code = 8'h30 + {2'b00, idx - 6'd52};
      end else if (idx == 6'd62) begin
         code = 8'h2B;
      end
      return code;
   endfunction

endpackage

// ===== design/b64se_queue.sv =====
// Short flop-based queue of completed groups between front and back ends.
// Depends on b64se_pkg.
module b64se_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  b64se_pkg::group_entry_type push_entry,
   input  logic                      pop,
   output b64se_pkg::group_entry_type head_entry,
   output b64se_pkg::queue_status_type status
);

   b64se_pkg::group_entry_type       slot_ff [b64se_pkg::QUEUE_DEPTH];
   logic [b64se_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [b64se_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [b64se_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                             do_push, do_pop;

   assign status.full  = (count_ff == b64se_pkg::QCNT_W'(b64se_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_entry   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == b64se_pkg::QPTR_W'(b64se_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == b64se_pkg::QPTR_W'(b64se_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/b64se_front.sv =====
// Front end: accepts bytes, gathers them into 24-bit groups, marks padding.
// Depends on b64se_pkg.
module b64se_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_is_last,
   input  b64se_pkg::queue_status_type q_status,
   output logic                       q_push,
   output b64se_pkg::group_entry_type  q_entry
);

   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        accept;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   always_comb begin
      held_bytes_in     = held_bytes_ff;
      held_count_in     = held_count_ff;
      q_push            = 1'b0;
      q_entry.group     = {held_bytes_ff, req_data_byte};
      q_entry.pad_count = 2'd0;
      q_entry.last      = req_is_last;
      case (held_count_ff)
         2'd0: begin
            q_entry.group     = {req_data_byte, 16'h0000};
            q_entry.pad_count = 2'd2;
         end
         2'd1: begin
            q_entry.group     = {held_bytes_ff[7:0], req_data_byte, 8'h00};
            q_entry.pad_count = 2'd1;
         end
         default: begin
            q_entry.group     = {held_bytes_ff, req_data_byte};
            q_entry.pad_count = 2'd0;
         end
      endcase
      if (accept) begin
         if (req_is_last || held_count_ff[1]) begin
            q_push        = 1'b1;
            held_bytes_in = '0;
            held_count_in = '0;
         end else begin
            held_bytes_in = {held_bytes_ff[7:0], req_data_byte};
            held_count_in = held_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff <= '0;
         held_count_ff <= '0;
      end else begin
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
      end
   end

endmodule

// ===== design/b64se_back.sv =====
// Back end: walks a queued group into the output register, one symbol per cycle while that register is free or popped.
// Depends on b64se_pkg.
module b64se_back (
   input  logic                       clock,
   input  logic                       reset,
   input  b64se_pkg::group_entry_type  q_entry,
   input  b64se_pkg::queue_status_type q_status,
   output logic                       q_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [7:0]                 rsp_out_char,
   output logic                       rsp_out_last
);

   logic [1:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       load;
   logic [5:0] sym_idx;
   logic       is_pad;

   assign rsp_empty    = !rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;
   assign rsp_out_last = rsp_last_ff;

   // output slot is free this cycle or is being drained
   assign load  = !q_status.empty && (!rsp_valid_ff || rsp_pop);
   assign q_pop = load && (pos_ff == 2'd3);

   always_comb begin
      case (pos_ff)
         2'd0:    sym_idx = q_entry.group[23:18];
         2'd1:    sym_idx = q_entry.group[17:12];
         2'd2:    sym_idx = q_entry.group[11:6];
         default: sym_idx = q_entry.group[5:0] & b64se_pkg::SIX_MASK;
      endcase
      // trailing positions beyond the data become '='
      is_pad = ({1'b0, pos_ff} + {1'b0, q_entry.pad_count}) > 3'd3;

      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (load) begin
         pos_in       = pos_ff + 1'b1;
         rsp_valid_in = 1'b1;
         rsp_char_in  = is_pad ? b64se_pkg::PAD_CHAR : b64se_pkg::symbol_char(sym_idx);
         rsp_last_in  = (pos_ff == 2'd3) && q_entry.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== design/base64_stream_encoder_core.sv =====
// Streaming base64 encoder. A byte is taken every cycle while the group queue
// has room; each group of up to three bytes leaves as four characters, one per
// cycle while the output is free or popped; the back end's single symbol path
// sets the sustained rate. The byte completing a group is written into a queue
// slot, and the group's first character then goes into the output register.
// Synchronous reset empties the queue, output and held bytes.
module base64_stream_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_last
);

   b64se_pkg::group_entry_type  push_entry;
   b64se_pkg::group_entry_type  head_entry;
   b64se_pkg::queue_status_type q_status;
   logic                        q_push;
   logic                        q_pop;

   b64se_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_is_last   (req_is_last),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_entry       (push_entry)
   );

   b64se_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .status     (q_status)
   );

   b64se_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_entry      (head_entry),
      .q_status     (q_status),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

endmodule

// ===== design/b64se_checker.sv =====
// Port-level checker for the base64 encoder, bound to the top level.
// Depends on b64se_pkg and base64_stream_encoder_core_macros.svh.
`include "base64_stream_encoder_core_macros.svh"

module b64se_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_char,
   input logic       rsp_out_last
);

   `B64SE_ASSERT_RESET(a_reset_empty, reset, rsp_empty, "output not empty after reset")
   `B64SE_ASSERT_RESET(a_reset_not_full, reset, !req_full, "input full after reset")
   `B64SE_ASSERT_NEXT(a_stall_holds, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_out_char) && $stable(rsp_out_last), "stalled word changed")
   // a '=' that is not the final character is the first of "==", and the second follows at once
   `B64SE_ASSERT_NEXT(a_pad_pair, rsp_pop && !rsp_empty && !rsp_out_last && rsp_out_char == b64se_pkg::PAD_CHAR, !rsp_empty && rsp_out_last && rsp_out_char == b64se_pkg::PAD_CHAR, "padding pair broken")

endmodule

bind base64_stream_encoder_core b64se_checker u_b64se_checker (
   .clock        (clock),
   .reset        (reset),
   .req_push     (req_push),
   .req_full     (req_full),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_out_char (rsp_out_char),
   .rsp_out_last (rsp_out_last)
);
